@@ sv/lss_pkg.sv @@
// Package for the LIFO stack with search: operation and status codes,
// controller states and the command and status structs between the units.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lss_pkg;

  localparam int unsigned StackDepth = 16;
  localparam int unsigned WordBits   = 32;

  localparam int unsigned ValueBits  = 32;
  localparam int unsigned CountBits  = 5;
  localparam int unsigned KindBits   = 2;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned OutFieldBits = ValueBits + 1 + CountBits + 1 + StatusBits;
  localparam int unsigned OutDataBits  = ((OutFieldBits + 7) / 8) * 8;

  typedef enum logic [KindBits-1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_POPRD = 6'b000100,
    S_SRCH  = 6'b001000,
    S_SDONE = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  typedef struct packed {
    logic load;
    logic push;
    logic pop;
    logic pop_rd;
    logic top_ld;
    logic scan_clr;
    logic scan_rd;
    logic ovf;
    logic unf;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [KindBits-1:0] kind;
    logic                full;
    logic                empty;
    logic                cnt_one;
    logic                scan_last;
    logic                out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ sv/lss_ctrl.sv @@
// Controller of the LIFO stack with search: sequences each item through
// execute, read, scan and emit steps. Depends on lss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lss_pkg::sts_t sts_i,
  output lss_pkg::cmd_t cmd_o
);

  lss_pkg::state_e state_q, state_d;

  assign in_ready_o = (state_q == lss_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      lss_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lss_pkg::S_EXEC;
        end
      end
      lss_pkg::S_EXEC: begin
        state_d = lss_pkg::S_EMIT;
        case (sts_i.kind)
          lss_pkg::KIND_PUSH: begin
            if (sts_i.full) begin
              cmd_o.ovf = 1'b1;
            end else begin
              cmd_o.push = 1'b1;
            end
          end
          lss_pkg::KIND_POP: begin
            if (sts_i.empty) begin
              cmd_o.unf = 1'b1;
            end else begin
              cmd_o.pop = 1'b1;
              if (!sts_i.cnt_one) begin
                cmd_o.pop_rd = 1'b1;
                state_d      = lss_pkg::S_POPRD;
              end
            end
          end
          lss_pkg::KIND_SEARCH: begin
            if (!sts_i.empty) begin
              cmd_o.scan_clr = 1'b1;
              state_d        = lss_pkg::S_SRCH;
            end
          end
          default: begin
            state_d = lss_pkg::S_EMIT;
          end
        endcase
      end
      lss_pkg::S_POPRD: begin
        cmd_o.top_ld = 1'b1;
        state_d      = lss_pkg::S_EMIT;
      end
      lss_pkg::S_SRCH: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = lss_pkg::S_SDONE;
        end
      end
      lss_pkg::S_SDONE: begin
        state_d = lss_pkg::S_EMIT;
      end
      lss_pkg::S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = lss_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lss_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lss_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/lss_dp.sv @@
// Datapath of the LIFO stack with search: entry memory, count, top register,
// search scan and result register. Depends on lss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lss_dp #(
  parameter int unsigned STACK_DEPTH = lss_pkg::StackDepth,
  parameter int unsigned WORD_BITS   = lss_pkg::WordBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [lss_pkg::KindBits-1:0]        kind_i,
  input  logic [lss_pkg::ValueBits-1:0]       value_i,
  input  lss_pkg::cmd_t                       cmd_i,
  output lss_pkg::sts_t                       sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [lss_pkg::ValueBits-1:0]       out_data_o,
  output logic                                out_found_o,
  output logic [lss_pkg::CountBits-1:0]       out_count_o,
  output logic                                out_empty_o,
  output logic [lss_pkg::StatusBits-1:0]      out_status_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned XW = (WORD_BITS > lss_pkg::ValueBits) ? WORD_BITS : lss_pkg::ValueBits;

  logic [WORD_BITS-1:0] mem_q [STACK_DEPTH];
  logic [WORD_BITS-1:0] rd_data_q;
  logic [WORD_BITS-1:0] top_q;
  logic [WORD_BITS-1:0] key_q;
  logic [WORD_BITS-1:0] popped_q;
  logic [lss_pkg::KindBits-1:0] kind_q;
  logic                 popped_sel_q;
  logic                 found_q;
  lss_pkg::status_e     status_q;
  logic [CW-1:0]        cnt_q;
  logic [AW-1:0]        idx_q;
  logic                 cmp_vld_q;
  logic                 out_vld_q;

  logic [XW-1:0]        value_ext;
  logic [CW-1:0]        pop_addr;
  logic [AW-1:0]        rd_addr;
  logic                 rd_en;
  logic                 empty;
  logic [WORD_BITS-1:0] res_word;
  logic [XW-1:0]        res_ext;
  logic [CW+lss_pkg::CountBits-1:0] cnt_wide;

  assign value_ext = XW'($signed(value_i));
  assign pop_addr  = cnt_q - CW'(2);
  assign rd_en     = cmd_i.pop_rd | cmd_i.scan_rd;
  assign rd_addr   = cmd_i.scan_rd ? idx_q : pop_addr[AW-1:0];
  assign empty     = (cnt_q == '0);

  assign sts_o.kind      = kind_q;
  assign sts_o.full      = (cnt_q == CW'(STACK_DEPTH));
  assign sts_o.empty     = empty;
  assign sts_o.cnt_one   = (cnt_q == CW'(1));
  assign sts_o.scan_last = (CW'(idx_q) == cnt_q - CW'(1));
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

  assign res_word = popped_sel_q ? popped_q : (empty ? '0 : top_q);
  assign res_ext  = XW'($signed(res_word));
  assign cnt_wide = (CW + lss_pkg::CountBits)'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[cnt_q[AW-1:0]] <= key_q;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q       <= kind_i;
      key_q        <= value_ext[WORD_BITS-1:0];
      popped_sel_q <= 1'b0;
      found_q      <= 1'b0;
      status_q     <= lss_pkg::ST_OK;
    end
    if (cmd_i.push) begin
      top_q <= key_q;
    end
    if (cmd_i.pop) begin
      popped_q     <= top_q;
      popped_sel_q <= 1'b1;
    end
    if (cmd_i.top_ld) begin
      top_q <= rd_data_q;
    end
    if (cmd_i.ovf) begin
      status_q <= lss_pkg::ST_OVERFLOW;
    end
    if (cmd_i.unf) begin
      status_q <= lss_pkg::ST_UNDERFLOW;
    end
    if (cmp_vld_q && (rd_data_q == key_q)) begin
      found_q <= 1'b1;
    end
    if (cmd_i.scan_clr) begin
      idx_q <= '0;
    end else if (cmd_i.scan_rd) begin
      idx_q <= idx_q + AW'(1);
    end
    if (cmd_i.emit) begin
      out_data_o   <= res_ext[lss_pkg::ValueBits-1:0];
      out_found_o  <= found_q;
      out_count_o  <= cnt_wide[lss_pkg::CountBits-1:0];
      out_empty_o  <= empty;
      out_status_o <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_rd;
      if (cmd_i.push) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.pop) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("Entry count exceeds the stack depth.");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> cnt_q < CW'(STACK_DEPTH))
    else $error("Push issued on a full stack.");

  a_pop_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> cnt_q != '0)
    else $error("Pop issued on an empty stack.");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_rd |-> CW'(idx_q) < cnt_q)
    else $error("Search read beyond the stored entries.");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> !$past(cmd_i.emit))
    else $error("Result overwritten while still held.");
`endif

endmodule

`default_nettype wire

@@ sv/lifo_stack_with_search_core.sv @@
// Top level of the LIFO stack with search: joins the controller and the
// datapath and packs the stream channels. Depends on lss_pkg, lss_ctrl, lss_dp.
//
//   Channel   Dir  tdata                          tuser
//   s_axis    in   value[31:0]                    kind[1:0]
//   m_axis    out  data, found, count, empty_res,  none
//                  status, zero pad to 48 bits
//
// One item is taken at a time. Push, pop to empty, underflow, unused kinds and a
// search of an empty stack go from execute straight to emit; a pop that leaves
// entries adds a read step for the new top. Any other search scans the entries and
// passes a done step before emit: the single memory read port scans one entry per
// cycle. Reset clears the count; entries stay unknown until pushed.
// A held result stalls the emit step, and no new item is accepted until it is emitted.
`timescale 1ns / 1ps
`default_nettype none

module lifo_stack_with_search_core #(
  parameter int unsigned STACK_DEPTH = lss_pkg::StackDepth,
  parameter int unsigned WORD_BITS   = lss_pkg::WordBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lss_pkg::ValueBits-1:0]    s_axis_tdata,  // value
  input  logic [lss_pkg::KindBits-1:0]     s_axis_tuser,  // kind
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lss_pkg::OutDataBits-1:0]  m_axis_tdata   // data, found, count, empty_res, status
);

  lss_pkg::cmd_t cmd;
  lss_pkg::sts_t sts;

  logic [lss_pkg::ValueBits-1:0]  out_data;
  logic                           out_found;
  logic [lss_pkg::CountBits-1:0]  out_count;
  logic                           out_empty;
  logic [lss_pkg::StatusBits-1:0] out_status;

  lss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lss_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_BITS   (WORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (s_axis_tuser),
    .value_i      (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (out_data),
    .out_found_o  (out_found),
    .out_count_o  (out_count),
    .out_empty_o  (out_empty),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = lss_pkg::OutDataBits'({out_status, out_empty, out_count,
                                               out_found, out_data});

endmodule

`default_nettype wire
